// ----- rtl/core/time_of_day_and_countdown_timers_core_assert.svh -----
// Assertion macros for the timekeeping core.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef TIME_OF_DAY_AND_COUNTDOWN_TIMERS_CORE_ASSERT_SVH
`define TIME_OF_DAY_AND_COUNTDOWN_TIMERS_CORE_ASSERT_SVH

// Same-cycle implication
`define TDCT_ASSERT_NOW(name, cond, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication
`define TDCT_ASSERT_NEXT(name, cond, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ----- rtl/core/tdct_pkg.sv -----
package tdct_pkg;

    // Byte map
    localparam int CLOCK_DEPTH      = 6;
    localparam int BYTES_PER_TIMER  = 4;
    localparam int NUM_TIMERS_DEF   = 4;
    localparam int ADDR_W           = 5;
    localparam int DATA_W           = 8;

    // Clock byte addresses
    localparam logic [2:0] ADDR_HUND  = 3'd0;
    localparam logic [2:0] ADDR_SEC   = 3'd1;
    localparam logic [2:0] ADDR_MIN   = 3'd2;
    localparam logic [2:0] ADDR_HOUR  = 3'd3;
    localparam logic [2:0] ADDR_DAY_L = 3'd4;
    localparam logic [2:0] ADDR_DAY_H = 3'd5;

    // Time-of-day wrap values
    localparam logic [7:0] HUND_STEP = 8'd2;
    localparam logic [7:0] HUND_WRAP = 8'd100;
    localparam logic [7:0] SEC_WRAP  = 8'd60;
    localparam logic [7:0] MIN_WRAP  = 8'd60;
    localparam logic [7:0] HOUR_WRAP = 8'd24;

    // Timer reload values
    localparam logic [7:0] TMR_HUND_RELOAD = 8'd98;
    localparam logic [7:0] TMR_SEC_RELOAD  = 8'd59;
    localparam logic [7:0] TMR_MIN_RELOAD  = 8'd255;
    localparam logic [7:0] TMR_EXPIRED     = 8'd1;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } opcode_t;

    // Per-timer control: tick or byte write
    typedef struct packed {
        logic        tick;
        logic        wr_en;
        logic [1:0]  idx;
        logic [7:0]  data;
    } timer_ctl_t;

endpackage

// ----- rtl/core/tdct_if.sv -----
// Command channel: one tick, write or read per transfer
interface tdct_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [4:0] byte_address;
    logic [7:0] write_data;

    modport source (output valid, opcode, byte_address, write_data, input ready);
    modport sink   (input valid, opcode, byte_address, write_data, output ready);
endinterface

// Response channel: one byte per command
interface tdct_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;

    modport source (output valid, read_data, input ready);
    modport sink   (input valid, read_data, output ready);
endinterface

// ----- rtl/core/tdct_timer.sv -----
// One countdown timer: four bytes, hundredths first.
module tdct_timer
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tdct_pkg::timer_ctl_t ctl,
    output logic [3:0][7:0]      bytes
);

    logic [3:0][7:0] bytes_reg;
    logic [3:0][7:0] bytes_next;

    // Countdown on tick, byte store on write
    always_comb
    begin
        bytes_next = bytes_reg;
        if (ctl.tick)
        begin
            if (!bytes_reg[0][0])
            begin
                if (bytes_reg[0] != 8'd0)
                begin
                    bytes_next[0] = bytes_reg[0] - tdct_pkg::HUND_STEP;
                end
                else if (bytes_reg[1] != 8'd0)
                begin
                    bytes_next[0] = tdct_pkg::TMR_HUND_RELOAD;
                    bytes_next[1] = bytes_reg[1] - 8'd1;
                end
                else if (bytes_reg[2] != 8'd0)
                begin
                    bytes_next[1] = tdct_pkg::TMR_SEC_RELOAD;
                    bytes_next[2] = bytes_reg[2] - 8'd1;
                end
                else if (bytes_reg[3] != 8'd0)
                begin
                    bytes_next[2] = tdct_pkg::TMR_MIN_RELOAD;
                    bytes_next[3] = bytes_reg[3] - 8'd1;
                end
                else
                begin
                    // all zero: expired, stops on odd value
                    bytes_next[0] = tdct_pkg::TMR_EXPIRED;
                end
            end
        end
        else if (ctl.wr_en)
        begin
            bytes_next[ctl.idx] = ctl.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_reg <= '0;
        end
        else
        begin
            bytes_reg <= bytes_next;
        end
    end

    assign bytes = bytes_reg;

endmodule

// ----- rtl/core/time_of_day_and_countdown_timers_core.sv -----
// Time-of-day clock with NUM_TIMERS countdown timers on a byte map: bytes 0-5 are
// hundredths, seconds, minutes, hours and a 16-bit day count (low, high); byte
// 6 + 4*t + k is byte k of timer t. A tick command advances the clock by 20 ms and
// counts down every timer whose first byte is even; a timer at all zeros sets its
// first byte to 1 and stops. Each command yields one response byte: the addressed
// byte after a write or read, zero for a tick or an unmapped address. The block
// takes one command per cycle; the response appears in the output register in the
// cycle after the transfer, and the command side stalls only while that register
// holds a byte the sink has not taken. All bytes clear at reset.
`include "time_of_day_and_countdown_timers_core_assert.svh"

module time_of_day_and_countdown_timers_core
#(
    parameter int NUM_TIMERS = tdct_pkg::NUM_TIMERS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    tdct_cmd_if.sink   cmd,
    tdct_rsp_if.source rsp
);

    localparam int TIMER_END = tdct_pkg::CLOCK_DEPTH + tdct_pkg::BYTES_PER_TIMER * NUM_TIMERS;

    logic [tdct_pkg::CLOCK_DEPTH-1:0][7:0]  clock_reg;
    logic [tdct_pkg::CLOCK_DEPTH-1:0][7:0]  clock_next;
    logic [NUM_TIMERS-1:0][3:0][7:0]        timer_bytes;
    tdct_pkg::timer_ctl_t [NUM_TIMERS-1:0]  timer_ctl;

    logic       rsp_valid_reg;
    logic [7:0] read_data_reg;
    logic [7:0] read_data_next;

    logic       cmd_xfer;
    logic       is_tick;
    logic       is_write;
    logic       is_read;
    logic       is_clock;
    logic       is_timer;
    logic [4:0] timer_off;
    logic [15:0] day_inc;

    // Handshake: single output register, refilled in the cycle it drains
    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign cmd_xfer  = cmd.valid && cmd.ready;

    // Command decode
    assign is_tick  = cmd_xfer && (cmd.opcode == tdct_pkg::OP_TICK);
    assign is_write = cmd_xfer && (cmd.opcode == tdct_pkg::OP_WRITE);
    assign is_read  = cmd_xfer && (cmd.opcode == tdct_pkg::OP_READ);
    assign is_clock = cmd.byte_address < 5'(tdct_pkg::CLOCK_DEPTH);
    assign is_timer = !is_clock && (6'(cmd.byte_address) < 6'(TIMER_END));
    assign timer_off = cmd.byte_address - 5'(tdct_pkg::CLOCK_DEPTH);
    assign day_inc  = {clock_reg[tdct_pkg::ADDR_DAY_H], clock_reg[tdct_pkg::ADDR_DAY_L]}
                      + 16'd1;

    // Time-of-day carry chain and clock byte writes
    always_comb
    begin
        clock_next = clock_reg;
        if (is_tick)
        begin
            clock_next[tdct_pkg::ADDR_HUND] = clock_reg[tdct_pkg::ADDR_HUND]
                                              + tdct_pkg::HUND_STEP;
            if (clock_next[tdct_pkg::ADDR_HUND] == tdct_pkg::HUND_WRAP)
            begin
                clock_next[tdct_pkg::ADDR_HUND] = 8'd0;
                clock_next[tdct_pkg::ADDR_SEC] = clock_reg[tdct_pkg::ADDR_SEC] + 8'd1;
                if (clock_next[tdct_pkg::ADDR_SEC] == tdct_pkg::SEC_WRAP)
                begin
                    clock_next[tdct_pkg::ADDR_SEC] = 8'd0;
                    clock_next[tdct_pkg::ADDR_MIN] = clock_reg[tdct_pkg::ADDR_MIN] + 8'd1;
                    if (clock_next[tdct_pkg::ADDR_MIN] == tdct_pkg::MIN_WRAP)
                    begin
                        clock_next[tdct_pkg::ADDR_MIN] = 8'd0;
                        clock_next[tdct_pkg::ADDR_HOUR] = clock_reg[tdct_pkg::ADDR_HOUR]
                                                          + 8'd1;
                        if (clock_next[tdct_pkg::ADDR_HOUR] == tdct_pkg::HOUR_WRAP)
                        begin
                            clock_next[tdct_pkg::ADDR_HOUR]  = 8'd0;
                            clock_next[tdct_pkg::ADDR_DAY_L] = day_inc[7:0];
                            clock_next[tdct_pkg::ADDR_DAY_H] = day_inc[15:8];
                        end
                    end
                end
            end
        end
        else if (is_write && is_clock)
        begin
            clock_next[cmd.byte_address[2:0]] = cmd.write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg <= '0;
        end
        else
        begin
            clock_reg <= clock_next;
        end
    end

    // Timers
    for (genvar t = 0; t < NUM_TIMERS; t++)
    begin : g_timer
        always_comb
        begin
            timer_ctl[t].tick  = is_tick;
            timer_ctl[t].wr_en = is_write && is_timer && (timer_off[4:2] == 3'(t));
            timer_ctl[t].idx   = timer_off[1:0];
            timer_ctl[t].data  = cmd.write_data;
        end

        tdct_timer u_timer
        (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (timer_ctl[t]),
            .bytes (timer_bytes[t])
        );
    end

    // Response byte: written value on write, stored byte on read
    always_comb
    begin
        read_data_next = 8'd0;
        if (is_write && (is_clock || is_timer))
        begin
            read_data_next = cmd.write_data;
        end
        else if (is_read && is_clock)
        begin
            read_data_next = clock_reg[cmd.byte_address[2:0]];
        end
        else if (is_read && is_timer)
        begin
            for (int t = 0; t < NUM_TIMERS; t++)
            begin
                if (timer_off[4:2] == 3'(t))
                begin
                    read_data_next = timer_bytes[t][timer_off[1:0]];
                end
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            read_data_reg <= 8'd0;
        end
        else
        begin
            if (cmd_xfer)
            begin
                rsp_valid_reg <= 1'b1;
                read_data_reg <= read_data_next;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.read_data = read_data_reg;

    // Checks
    `TDCT_ASSERT_NEXT(a_rsp_follows_cmd, cmd_xfer, rsp_valid_reg,
        "response register not loaded after a command transfer")
    `TDCT_ASSERT_NOW(a_stall_blocks_cmd, rsp_valid_reg && !rsp.ready, !cmd.ready,
        "command taken while response register is stalled")
    `TDCT_ASSERT_NEXT(a_tick_reads_zero, is_tick, read_data_reg == 8'd0,
        "tick produced a nonzero response byte")
    `TDCT_ASSERT_NEXT(a_hund_write, is_write && (cmd.byte_address == 5'd0),
        clock_reg[tdct_pkg::ADDR_HUND] == $past(cmd.write_data),
        "hundredths byte write lost")

endmodule
